>>> hw/rtl/bls_pkg.sv
package bls_pkg;

  // Stack geometry
  localparam int DEPTH = 64;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = 32;

  typedef logic [1:0] op_t;
  typedef logic [2:0] status_t;

  // Operation codes
  localparam op_t OP_PUSH    = 2'd0;
  localparam op_t OP_POP     = 2'd1;
  localparam op_t OP_SEARCH  = 2'd2;
  localparam op_t OP_DISPLAY = 2'd3;

  // Result status codes
  localparam status_t ST_PUSHED    = 3'd0;
  localparam status_t ST_OVERFLOW  = 3'd1;
  localparam status_t ST_POPPED    = 3'd2;
  localparam status_t ST_UNDERFLOW = 3'd3;
  localparam status_t ST_FOUND     = 3'd4;
  localparam status_t ST_NOTFOUND  = 3'd5;
  localparam status_t ST_ELEMENT   = 3'd6;

endpackage

>>> hw/rtl/bls_ram.sv
module bls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/bounded_lifo_stack_with_search.sv
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+--------------------------------
// input    | in_operation, in_value                  | word taken when start && !busy
// result   | out_status, out_data, out_last          | out_valid for one cycle, no stall
//
// Push never raises busy: the word is written at the accepting edge, which also registers its result.
// Pop holds busy in S_POP while the single memory read port returns the top word.
// Search and display hold busy while they scan, one entry per cycle through the
// memory read port; each read word passes the registered memory output, then the result registers.
// Reset (rst_n low, synchronous) empties the stack; the store itself is not cleared.
// The receiver cannot stall: every result is presented for exactly one cycle.
module bounded_lifo_stack_with_search
  import bls_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_operation,
  input  logic signed [31:0]   in_value,
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic signed [31:0]   out_data,
  output logic                 out_last
);

  // Sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        left_r, left_nxt;    // entries still to be consumed in a scan
  logic [AW-1:0]        ptr_r, ptr_nxt;      // next address to read in a scan
  op_t                  op_r, op_nxt;
  logic [DW-1:0]        value_r, value_nxt;

  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [DW-1:0]        out_data_r, out_data_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 accept;
  logic                 full, empty;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [DW-1:0]        ram_rdata;
  logic [AW-1:0]        top_addr;
  logic                 hit;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign top_addr = AW'(count_r - 1'b1);

  // Single compare unit: one stored entry against the search word per cycle
  assign hit = (ram_rdata == value_r);

  // Write port follows a push straight from the inputs
  assign ram_we    = accept && (in_operation == OP_PUSH) && !full;
  assign ram_waddr = AW'(count_r);

  bls_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    left_nxt       = left_r;
    ptr_nxt        = ptr_r;
    op_nxt         = op_r;
    value_nxt      = value_r;
    ram_raddr      = ptr_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_NOTFOUND;
    out_data_nxt   = '0;
    out_last_nxt   = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        // Aim the read port at the word the new item needs first
        ram_raddr = (in_operation == OP_SEARCH) ? '0 : top_addr;
        if (accept) begin
          op_nxt    = in_operation;
          value_nxt = in_value;
          unique case (in_operation)
            OP_PUSH: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_status_nxt = ST_OVERFLOW;
              end else begin
                out_status_nxt = ST_PUSHED;
                count_nxt      = count_r + 1'b1;
              end
            end
            OP_POP: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_UNDERFLOW;
              end else begin
                count_nxt = count_r - 1'b1;
                state_nxt = S_POP;
              end
            end
            default: begin
              // Search walks upward from the bottom, display downward from the top
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_NOTFOUND;
              end else begin
                left_nxt  = count_r;
                ptr_nxt   = (in_operation == OP_SEARCH) ? AW'(1) : top_addr - 1'b1;
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end

      S_POP: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_POPPED;
        out_data_nxt   = ram_rdata;
        state_nxt      = S_IDLE;
      end

      S_SCAN: begin
        // Issue the next read while consuming the word returned for the last one
        ram_raddr = ptr_r;
        ptr_nxt   = (op_r == OP_SEARCH) ? ptr_r + 1'b1 : ptr_r - 1'b1;
        left_nxt  = left_r - 1'b1;
        if (op_r == OP_SEARCH) begin
          if (hit) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_FOUND;
            state_nxt      = S_IDLE;
          end else if (left_r == CW'(1)) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_NOTFOUND;
            state_nxt      = S_IDLE;
          end
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_ELEMENT;
          out_data_nxt   = ram_rdata;
          out_last_nxt   = (left_r == CW'(1));
          if (left_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and scan working registers
  always_ff @(posedge clk) begin
    left_r       <= left_nxt;
    ptr_r        <= ptr_nxt;
    op_r         <= op_nxt;
    value_r      <= value_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("busy still high after final result");

  a_mid_is_element: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_status == ST_ELEMENT))
    else $error("non-final result is not an element");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_operation == OP_PUSH) && !full) |=>
      (count_r == CW'($past(count_r) + 1'b1)))
    else $error("push did not grow the stack");

  a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ((left_r != '0) && (left_r <= count_r)))
    else $error("scan counter out of range");
`endif

endmodule
